### sv/sm83_pkg.sv
package sm83_pkg;

    localparam logic [7:0] PREFIX_OP = 8'hCB;
    localparam logic [7:0] HALT_OP   = 8'h76;

    localparam logic [5:0] MN_NOP  = 6'd0;
    localparam logic [5:0] MN_STOP = 6'd1;
    localparam logic [5:0] MN_HALT = 6'd2;
    localparam logic [5:0] MN_DI   = 6'd3;
    localparam logic [5:0] MN_EI   = 6'd4;
    localparam logic [5:0] MN_LD   = 6'd5;
    localparam logic [5:0] MN_LDH  = 6'd6;
    localparam logic [5:0] MN_PUSH = 6'd7;
    localparam logic [5:0] MN_POP  = 6'd8;
    localparam logic [5:0] MN_ADD  = 6'd9;
    localparam logic [5:0] MN_INC  = 6'd17;
    localparam logic [5:0] MN_DEC  = 6'd18;
    localparam logic [5:0] MN_JP   = 6'd27;
    localparam logic [5:0] MN_JR   = 6'd28;
    localparam logic [5:0] MN_CALL = 6'd29;
    localparam logic [5:0] MN_RET  = 6'd30;
    localparam logic [5:0] MN_RETI = 6'd31;
    localparam logic [5:0] MN_RST  = 6'd32;
    localparam logic [5:0] MN_RLC  = 6'd33;
    localparam logic [5:0] MN_BIT  = 6'd41;
    localparam logic [5:0] MN_INV  = 6'd44;

    localparam logic [5:0] OPD_NONE    = 6'd0;
    localparam logic [5:0] OPD_A       = 6'd1;
    localparam logic [5:0] OPD_HL      = 6'd11;
    localparam logic [5:0] OPD_SP      = 6'd12;
    localparam logic [5:0] OPD_IND_HL  = 6'd15;
    localparam logic [5:0] OPD_IND_C   = 6'd18;
    localparam logic [5:0] OPD_D8      = 6'd19;
    localparam logic [5:0] OPD_D16     = 6'd20;
    localparam logic [5:0] OPD_IND_A8  = 6'd21;
    localparam logic [5:0] OPD_IND_A16 = 6'd22;
    localparam logic [5:0] OPD_SP_R8   = 6'd23;
    localparam logic [5:0] OPD_COND0   = 6'd24;
    localparam logic [5:0] OPD_BIT0    = 6'd28;
    localparam logic [5:0] OPD_RST0    = 6'd36;

    localparam logic [3:0] BR_NONE  = 4'd0;
    localparam logic [3:0] BR_JUMP  = 4'd1;
    localparam logic [3:0] BR_CJUMP = 4'd2;
    localparam logic [3:0] BR_IND   = 4'd3;
    localparam logic [3:0] BR_CALL  = 4'd4;
    localparam logic [3:0] BR_CCALL = 4'd5;
    localparam logic [3:0] BR_RET   = 4'd6;
    localparam logic [3:0] BR_CRET  = 4'd7;
    localparam logic [3:0] BR_RST   = 4'd8;
    localparam logic [3:0] BR_HALT  = 4'd9;
    localparam logic [3:0] BR_STOP  = 4'd10;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [1:0] bytes_valid;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  mnemonic_code;
        logic [5:0]  first_operand;
        logic [5:0]  second_operand;
        logic [1:0]  length_bytes;
        logic [4:0]  base_cycles;
        logic [4:0]  taken_cycles;
        logic [3:0]  branch_kind;
        logic        prefixed;
        logic [7:0]  opcode_value;
        logic [7:0]  short_immediate;
        logic [15:0] long_immediate;
    } out_word_t;

    function automatic logic [5:0] reg8_code(input logic [2:0] r);
        logic [5:0] c;
        case (r)
            3'd0: c = 6'd2;
            3'd1: c = 6'd3;
            3'd2: c = 6'd4;
            3'd3: c = 6'd5;
            3'd4: c = 6'd6;
            3'd5: c = 6'd7;
            3'd6: c = 6'd15;
            default: c = 6'd1;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] reg16_code(input logic [1:0] p);
        return 6'd9 + {4'd0, p};
    endfunction

    function automatic logic [5:0] stack16_code(input logic [1:0] p);
        return (p == 2'd3) ? 6'd8 : 6'd9 + {4'd0, p};
    endfunction

    function automatic logic [5:0] ind_a_code(input logic [1:0] p);
        logic [5:0] c;
        case (p)
            2'd0: c = 6'd13;
            2'd1: c = 6'd14;
            2'd2: c = 6'd16;
            default: c = 6'd17;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] misc_code(input logic [2:0] y);
        logic [5:0] c;
        case (y)
            3'd0: c = 6'd23;
            3'd1: c = 6'd24;
            3'd2: c = 6'd25;
            3'd3: c = 6'd26;
            3'd4: c = 6'd19;
            3'd5: c = 6'd20;
            3'd6: c = 6'd21;
            default: c = 6'd22;
        endcase
        return c;
    endfunction

endpackage

### sv/sm83_decode.sv
module instr_decode_table (
    input  sm83_pkg::in_word_t  in_word,
    output sm83_pkg::out_word_t out_word
);
    import sm83_pkg::*;

    logic [7:0] op;
    logic [7:0] cb;
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    logic [2:0] cr;
    logic [1:0] cx;
    logic [2:0] cbit;
    logic       need8;
    logic       need16;
    out_word_t  d;

    assign op   = in_word.first_byte;
    assign cb   = in_word.second_byte;
    assign x    = op[7:6];
    assign y    = op[5:3];
    assign z    = op[2:0];
    assign p    = op[5:4];
    assign q    = op[3];
    assign cr   = cb[2:0];
    assign cbit = cb[5:3];
    assign cx   = cb[7:6];

    always_comb
    begin
        d = '0;
        d.mnemonic_code = MN_INV;
        d.length_bytes  = 2'd1;
        d.base_cycles   = 5'd4;
        need8  = 1'b0;
        need16 = 1'b0;
        if (in_word.bytes_valid == 2'd0)
        begin
            d.opcode_value = 8'd0;
        end
        else if (op == PREFIX_OP)
        begin
            d.opcode_value = op;
            if (in_word.bytes_valid >= 2'd2)
            begin
                d.prefixed     = 1'b1;
                d.opcode_value = cb;
                d.length_bytes = 2'd2;
                if (cx == 2'd0)
                begin
                    d.mnemonic_code = MN_RLC + {3'd0, cbit};
                    d.first_operand = reg8_code(cr);
                    d.base_cycles   = (cr == 3'd6) ? 5'd16 : 5'd8;
                end
                else
                begin
                    d.mnemonic_code  = MN_BIT + {4'd0, cx - 2'd1};
                    d.first_operand  = OPD_BIT0 + {3'd0, cbit};
                    d.second_operand = reg8_code(cr);
                    d.base_cycles    = (cr != 3'd6) ? 5'd8 : ((cx == 2'd1) ? 5'd12 : 5'd16);
                end
            end
        end
        else
        begin
            d.opcode_value = op;
            unique case (x)
                2'd0:
                begin
                    unique case (z)
                        3'd0:
                        begin
                            if (y == 3'd0)
                            begin
                                d.mnemonic_code = MN_NOP;
                            end
                            else if (y == 3'd1)
                            begin
                                d.mnemonic_code = MN_LD;
                                d.first_operand = OPD_IND_A16;
                                d.second_operand = OPD_SP;
                                d.length_bytes = 2'd3;
                                d.base_cycles = 5'd20;
                                need16 = 1'b1;
                            end
                            else if (y == 3'd2)
                            begin
                                d.mnemonic_code = MN_STOP;
                                d.length_bytes = 2'd2;
                                d.branch_kind = BR_STOP;
                            end
                            else if (y == 3'd3)
                            begin
                                d.mnemonic_code = MN_JR;
                                d.first_operand = OPD_D8;
                                d.length_bytes = 2'd2;
                                d.base_cycles = 5'd12;
                                d.branch_kind = BR_JUMP;
                                need8 = 1'b1;
                            end
                            else
                            begin
                                d.mnemonic_code = MN_JR;
                                d.first_operand = OPD_COND0 + {4'd0, y[1:0]};
                                d.second_operand = OPD_D8;
                                d.length_bytes = 2'd2;
                                d.base_cycles = 5'd8;
                                d.taken_cycles = 5'd12;
                                d.branch_kind = BR_CJUMP;
                                need8 = 1'b1;
                            end
                        end
                        3'd1:
                        begin
                            if (!q)
                            begin
                                d.mnemonic_code = MN_LD;
                                d.first_operand = reg16_code(p);
                                d.second_operand = OPD_D16;
                                d.length_bytes = 2'd3;
                                d.base_cycles = 5'd12;
                                need16 = 1'b1;
                            end
                            else
                            begin
                                d.mnemonic_code = MN_ADD;
                                d.first_operand = OPD_HL;
                                d.second_operand = reg16_code(p);
                                d.base_cycles = 5'd8;
                            end
                        end
                        3'd2:
                        begin
                            d.mnemonic_code = MN_LD;
                            d.first_operand = q ? OPD_A : ind_a_code(p);
                            d.second_operand = q ? ind_a_code(p) : OPD_A;
                            d.base_cycles = 5'd8;
                        end
                        3'd3:
                        begin
                            d.mnemonic_code = q ? MN_DEC : MN_INC;
                            d.first_operand = reg16_code(p);
                            d.base_cycles = 5'd8;
                        end
                        3'd4, 3'd5:
                        begin
                            d.mnemonic_code = (z == 3'd4) ? MN_INC : MN_DEC;
                            d.first_operand = reg8_code(y);
                            d.base_cycles = (y == 3'd6) ? 5'd12 : 5'd4;
                        end
                        3'd6:
                        begin
                            d.mnemonic_code = MN_LD;
                            d.first_operand = reg8_code(y);
                            d.second_operand = OPD_D8;
                            d.length_bytes = 2'd2;
                            d.base_cycles = (y == 3'd6) ? 5'd12 : 5'd8;
                            need8 = 1'b1;
                        end
                        default:
                        begin
                            d.mnemonic_code = misc_code(y);
                        end
                    endcase
                end
                2'd1:
                begin
                    if (op == HALT_OP)
                    begin
                        d.mnemonic_code = MN_HALT;
                        d.branch_kind = BR_HALT;
                    end
                    else
                    begin
                        d.mnemonic_code = MN_LD;
                        d.first_operand = reg8_code(y);
                        d.second_operand = reg8_code(z);
                        d.base_cycles = (y == 3'd6 || z == 3'd6) ? 5'd8 : 5'd4;
                    end
                end
                2'd2:
                begin
                    d.mnemonic_code = MN_ADD + {3'd0, y};
                    d.first_operand = reg8_code(z);
                    d.base_cycles = (z == 3'd6) ? 5'd8 : 5'd4;
                end
                default:
                begin
                    unique case (z)
                        3'd0:
                        begin
                            d.length_bytes = 2'd2;
                            d.base_cycles = 5'd12;
                            need8 = 1'b1;
                            case (y)
                                3'd4:
                                begin
                                    d.mnemonic_code = MN_LDH;
                                    d.first_operand = OPD_IND_A8;
                                    d.second_operand = OPD_A;
                                end
                                3'd5:
                                begin
                                    d.mnemonic_code = MN_ADD;
                                    d.first_operand = OPD_SP;
                                    d.second_operand = OPD_D8;
                                    d.base_cycles = 5'd16;
                                end
                                3'd6:
                                begin
                                    d.mnemonic_code = MN_LDH;
                                    d.first_operand = OPD_A;
                                    d.second_operand = OPD_IND_A8;
                                end
                                3'd7:
                                begin
                                    d.mnemonic_code = MN_LD;
                                    d.first_operand = OPD_HL;
                                    d.second_operand = OPD_SP_R8;
                                end
                                default:
                                begin
                                    d.mnemonic_code = MN_RET;
                                    d.first_operand = OPD_COND0 + {3'd0, y};
                                    d.length_bytes = 2'd1;
                                    d.base_cycles = 5'd8;
                                    d.taken_cycles = 5'd20;
                                    d.branch_kind = BR_CRET;
                                    need8 = 1'b0;
                                end
                            endcase
                        end
                        3'd1:
                        begin
                            if (!q)
                            begin
                                d.mnemonic_code = MN_POP;
                                d.first_operand = stack16_code(p);
                                d.base_cycles = 5'd12;
                            end
                            else if (p == 2'd0 || p == 2'd1)
                            begin
                                d.mnemonic_code = p[0] ? MN_RETI : MN_RET;
                                d.base_cycles = 5'd16;
                                d.branch_kind = BR_RET;
                            end
                            else if (p == 2'd2)
                            begin
                                d.mnemonic_code = MN_JP;
                                d.first_operand = OPD_IND_HL;
                                d.branch_kind = BR_IND;
                            end
                            else
                            begin
                                d.mnemonic_code = MN_LD;
                                d.first_operand = OPD_SP;
                                d.second_operand = OPD_HL;
                                d.base_cycles = 5'd8;
                            end
                        end
                        3'd2:
                        begin
                            case (y)
                                3'd4:
                                begin
                                    d.mnemonic_code = MN_LD;
                                    d.first_operand = OPD_IND_C;
                                    d.second_operand = OPD_A;
                                    d.base_cycles = 5'd8;
                                end
                                3'd5:
                                begin
                                    d.mnemonic_code = MN_LD;
                                    d.first_operand = OPD_IND_A16;
                                    d.second_operand = OPD_A;
                                    d.length_bytes = 2'd3;
                                    d.base_cycles = 5'd16;
                                    need16 = 1'b1;
                                end
                                3'd6:
                                begin
                                    d.mnemonic_code = MN_LD;
                                    d.first_operand = OPD_A;
                                    d.second_operand = OPD_IND_C;
                                    d.base_cycles = 5'd8;
                                end
                                3'd7:
                                begin
                                    d.mnemonic_code = MN_LD;
                                    d.first_operand = OPD_A;
                                    d.second_operand = OPD_IND_A16;
                                    d.length_bytes = 2'd3;
                                    d.base_cycles = 5'd16;
                                    need16 = 1'b1;
                                end
                                default:
                                begin
                                    d.mnemonic_code = MN_JP;
                                    d.first_operand = OPD_COND0 + {3'd0, y};
                                    d.second_operand = OPD_D16;
                                    d.length_bytes = 2'd3;
                                    d.base_cycles = 5'd12;
                                    d.taken_cycles = 5'd16;
                                    d.branch_kind = BR_CJUMP;
                                    need16 = 1'b1;
                                end
                            endcase
                        end
                        3'd3:
                        begin
                            if (y == 3'd0)
                            begin
                                d.mnemonic_code = MN_JP;
                                d.first_operand = OPD_D16;
                                d.length_bytes = 2'd3;
                                d.base_cycles = 5'd16;
                                d.branch_kind = BR_JUMP;
                                need16 = 1'b1;
                            end
                            else if (y == 3'd6)
                            begin
                                d.mnemonic_code = MN_DI;
                            end
                            else if (y == 3'd7)
                            begin
                                d.mnemonic_code = MN_EI;
                            end
                        end
                        3'd4:
                        begin
                            if (!y[2])
                            begin
                                d.mnemonic_code = MN_CALL;
                                d.first_operand = OPD_COND0 + {3'd0, y};
                                d.second_operand = OPD_D16;
                                d.length_bytes = 2'd3;
                                d.base_cycles = 5'd12;
                                d.taken_cycles = 5'd24;
                                d.branch_kind = BR_CCALL;
                                need16 = 1'b1;
                            end
                        end
                        3'd5:
                        begin
                            if (!q)
                            begin
                                d.mnemonic_code = MN_PUSH;
                                d.first_operand = stack16_code(p);
                                d.base_cycles = 5'd16;
                            end
                            else if (p == 2'd0)
                            begin
                                d.mnemonic_code = MN_CALL;
                                d.first_operand = OPD_D16;
                                d.length_bytes = 2'd3;
                                d.base_cycles = 5'd24;
                                d.branch_kind = BR_CALL;
                                need16 = 1'b1;
                            end
                        end
                        3'd6:
                        begin
                            d.mnemonic_code = MN_ADD + {3'd0, y};
                            d.first_operand = OPD_D8;
                            d.length_bytes = 2'd2;
                            d.base_cycles = 5'd8;
                            need8 = 1'b1;
                        end
                        default:
                        begin
                            d.mnemonic_code = MN_RST;
                            d.first_operand = OPD_RST0 + {3'd0, y};
                            d.base_cycles = 5'd16;
                            d.branch_kind = BR_RST;
                        end
                    endcase
                end
            endcase
            if (need8 && in_word.bytes_valid >= 2'd2)
            begin
                d.short_immediate = cb;
            end
            if (need16 && in_word.bytes_valid == 2'd3)
            begin
                d.long_immediate = {in_word.third_byte, cb};
            end
        end
    end

    assign out_word = d;

endmodule

### sv/eight_bit_cpu_instruction_decoder.sv
// SM83 instruction decoder. Each word of up to three instruction bytes and a
// valid count yields one decoded word: mnemonic, operands, length, cycle
// counts, branch kind, prefix flag, opcode and immediates. One word is taken
// every cycle unless in_stall is high. The path is an input register, the
// decode table and a result register. in_stall rises only when the result
// register is full and held by out_stall with the input register also full.
module eight_bit_cpu_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  first_byte,
    input  logic [7:0]  second_byte,
    input  logic [7:0]  third_byte,
    input  logic [1:0]  bytes_valid,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  mnemonic_code,
    output logic [5:0]  first_operand,
    output logic [5:0]  second_operand,
    output logic [1:0]  length_bytes,
    output logic [4:0]  base_cycles,
    output logic [4:0]  taken_cycles,
    output logic [3:0]  branch_kind,
    output logic        prefixed,
    output logic [7:0]  opcode_value,
    output logic [7:0]  short_immediate,
    output logic [15:0] long_immediate
);
    import sm83_pkg::*;

    in_word_t  in_reg;
    logic      in_valid_reg;
    out_word_t dec_word;
    out_word_t out_reg;
    logic      out_valid_reg;
    logic      out_load;
    logic      in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    instr_decode_table u_decode (
        .in_word  (in_reg),
        .out_word (dec_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= '{first_byte, second_byte, third_byte, bytes_valid};
        end
        if (out_load)
        begin
            out_reg <= dec_word;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mnemonic_code   = out_reg.mnemonic_code;
    assign first_operand   = out_reg.first_operand;
    assign second_operand  = out_reg.second_operand;
    assign length_bytes    = out_reg.length_bytes;
    assign base_cycles     = out_reg.base_cycles;
    assign taken_cycles    = out_reg.taken_cycles;
    assign branch_kind     = out_reg.branch_kind;
    assign prefixed        = out_reg.prefixed;
    assign opcode_value    = out_reg.opcode_value;
    assign short_immediate = out_reg.short_immediate;
    assign long_immediate  = out_reg.long_immediate;

endmodule

### tb/tb.sv
module tb;
    import sm83_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
    logic [1:0]  bytes_valid;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  mnemonic_code;
    logic [5:0]  first_operand;
    logic [5:0]  second_operand;
    logic [1:0]  length_bytes;
    logic [4:0]  base_cycles;
    logic [4:0]  taken_cycles;
    logic [3:0]  branch_kind;
    logic        prefixed;
    logic [7:0]  opcode_value;
    logic [7:0]  short_immediate;
    logic [15:0] long_immediate;

    eight_bit_cpu_instruction_decoder dut (.*);

    int errors = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [5:0] r8(input logic [2:0] r);
        logic [5:0] t[8] = '{6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, OPD_IND_HL, OPD_A};
        return t[r];
    endfunction

    function automatic void set_basic(inout out_word_t d, input int m, input int a,
                                      input int b, input int l, input int c);
        d.mnemonic_code = 6'(m);
        d.first_operand = 6'(a);
        d.second_operand = 6'(b);
        d.length_bytes = 2'(l);
        d.base_cycles = 5'(c);
    endfunction

    function automatic out_word_t decode_word(input in_word_t w);
        out_word_t d;
        logic [7:0] op;
        logic [1:0] x, p;
        logic [2:0] y, z;
        logic q, n8, n16;
        logic [5:0] r16[4] = '{6'd9, 6'd10, 6'd11, 6'd12};
        logic [5:0] s16[4] = '{6'd9, 6'd10, 6'd11, 6'd8};
        logic [5:0] ia[4] = '{6'd13, 6'd14, 6'd16, 6'd17};
        logic [5:0] ms[8] = '{6'd23, 6'd24, 6'd25, 6'd26, 6'd19, 6'd20, 6'd21, 6'd22};
        d = '0;
        d.mnemonic_code = MN_INV;
        d.length_bytes = 2'd1;
        d.base_cycles = 5'd4;
        n8 = 1'b0;
        n16 = 1'b0;
        op = w.first_byte;
        if (w.bytes_valid == 2'd0) return d;
        d.opcode_value = op;
        if (op == PREFIX_OP) begin
            if (w.bytes_valid >= 2'd2) begin
                op = w.second_byte;
                d.prefixed = 1'b1;
                d.opcode_value = op;
                d.length_bytes = 2'd2;
                if (op < 8'h40) begin
                    d.mnemonic_code = MN_RLC + 6'(op >> 3);
                    d.first_operand = r8(op[2:0]);
                    d.base_cycles = (op[2:0] == 3'd6) ? 5'd16 : 5'd8;
                end else begin
                    d.mnemonic_code = MN_BIT + 6'(op[7:6] - 1);
                    d.first_operand = OPD_BIT0 + 6'(op[5:3]);
                    d.second_operand = r8(op[2:0]);
                    d.base_cycles = (op[2:0] == 3'd6) ? ((op < 8'h80) ? 5'd12 : 5'd16) : 5'd8;
                end
            end
            return d;
        end
        x = op[7:6]; y = op[5:3]; z = op[2:0]; p = y[2:1]; q = y[0];
        case (x)
            2'd0: case (z)
                0: if (y == 0) set_basic(d, MN_NOP, 0, 0, 1, 4);
                   else if (y == 1) begin set_basic(d, MN_LD, OPD_IND_A16, OPD_SP, 3, 20);
                       n16 = 1'b1; end
                   else if (y == 2) begin set_basic(d, MN_STOP, 0, 0, 2, 4);
                       d.branch_kind = BR_STOP; end
                   else if (y == 3) begin set_basic(d, MN_JR, OPD_D8, 0, 2, 12);
                       d.branch_kind = BR_JUMP; n8 = 1'b1; end
                   else begin set_basic(d, MN_JR, OPD_COND0 + 6'(y - 4), OPD_D8, 2, 8);
                       d.taken_cycles = 5'd12; d.branch_kind = BR_CJUMP; n8 = 1'b1; end
                1: if (!q) begin set_basic(d, MN_LD, r16[p], OPD_D16, 3, 12); n16 = 1'b1; end
                   else set_basic(d, MN_ADD, OPD_HL, r16[p], 1, 8);
                2: if (!q) set_basic(d, MN_LD, ia[p], OPD_A, 1, 8);
                   else set_basic(d, MN_LD, OPD_A, ia[p], 1, 8);
                3: set_basic(d, q ? MN_DEC : MN_INC, r16[p], 0, 1, 8);
                4, 5: set_basic(d, (z == 4) ? MN_INC : MN_DEC, r8(y), 0, 1, (y == 6) ? 12 : 4);
                6: begin set_basic(d, MN_LD, r8(y), OPD_D8, 2, (y == 6) ? 12 : 8); n8 = 1'b1; end
                default: set_basic(d, ms[y], 0, 0, 1, 4);
            endcase
            2'd1: if (op == HALT_OP) begin set_basic(d, MN_HALT, 0, 0, 1, 4);
                      d.branch_kind = BR_HALT; end
                  else set_basic(d, MN_LD, r8(y), r8(z), 1, (y == 6 || z == 6) ? 8 : 4);
            2'd2: set_basic(d, MN_ADD + 6'(y), r8(z), 0, 1, (z == 6) ? 8 : 4);
            default: case (z)
                0: if (y <= 3) begin set_basic(d, MN_RET, OPD_COND0 + 6'(y), 0, 1, 8);
                       d.taken_cycles = 5'd20; d.branch_kind = BR_CRET; end
                   else begin
                       n8 = 1'b1;
                       if (y == 4) set_basic(d, MN_LDH, OPD_IND_A8, OPD_A, 2, 12);
                       else if (y == 5) set_basic(d, MN_ADD, OPD_SP, OPD_D8, 2, 16);
                       else if (y == 6) set_basic(d, MN_LDH, OPD_A, OPD_IND_A8, 2, 12);
                       else set_basic(d, MN_LD, OPD_HL, OPD_SP_R8, 2, 12);
                   end
                1: if (!q) set_basic(d, MN_POP, s16[p], 0, 1, 12);
                   else if (p == 0) begin set_basic(d, MN_RET, 0, 0, 1, 16);
                       d.branch_kind = BR_RET; end
                   else if (p == 1) begin set_basic(d, MN_RETI, 0, 0, 1, 16);
                       d.branch_kind = BR_RET; end
                   else if (p == 2) begin set_basic(d, MN_JP, OPD_IND_HL, 0, 1, 4);
                       d.branch_kind = BR_IND; end
                   else set_basic(d, MN_LD, OPD_SP, OPD_HL, 1, 8);
                2: if (y <= 3) begin set_basic(d, MN_JP, OPD_COND0 + 6'(y), OPD_D16, 3, 12);
                       d.taken_cycles = 5'd16; d.branch_kind = BR_CJUMP; n16 = 1'b1; end
                   else if (y == 4) set_basic(d, MN_LD, OPD_IND_C, OPD_A, 1, 8);
                   else if (y == 5) begin set_basic(d, MN_LD, OPD_IND_A16, OPD_A, 3, 16);
                       n16 = 1'b1; end
                   else if (y == 6) set_basic(d, MN_LD, OPD_A, OPD_IND_C, 1, 8);
                   else begin set_basic(d, MN_LD, OPD_A, OPD_IND_A16, 3, 16); n16 = 1'b1; end
                3: if (y == 0) begin set_basic(d, MN_JP, OPD_D16, 0, 3, 16);
                       d.branch_kind = BR_JUMP; n16 = 1'b1; end
                   else if (y == 6) set_basic(d, MN_DI, 0, 0, 1, 4);
                   else if (y == 7) set_basic(d, MN_EI, 0, 0, 1, 4);
                4: if (y <= 3) begin set_basic(d, MN_CALL, OPD_COND0 + 6'(y), OPD_D16, 3, 12);
                       d.taken_cycles = 5'd24; d.branch_kind = BR_CCALL; n16 = 1'b1; end
                5: if (!q) set_basic(d, MN_PUSH, s16[p], 0, 1, 16);
                   else if (p == 0) begin set_basic(d, MN_CALL, OPD_D16, 0, 3, 24);
                       d.branch_kind = BR_CALL; n16 = 1'b1; end
                6: begin set_basic(d, MN_ADD + 6'(y), OPD_D8, 0, 2, 8); n8 = 1'b1; end
                default: begin set_basic(d, MN_RST, OPD_RST0 + 6'(y), 0, 1, 16);
                    d.branch_kind = BR_RST; end
            endcase
        endcase
        if (n8 && w.bytes_valid >= 2'd2) d.short_immediate = w.second_byte;
        if (n16 && w.bytes_valid == 2'd3) d.long_immediate = {w.third_byte, w.second_byte};
        return d;
    endfunction

    class decode_scoreboard;
        out_word_t pending[$];

        function void note_input(in_word_t w);
            pending.push_back(decode_word(w));
        endfunction

        task check_result(out_word_t got);
            out_word_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.mnemonic_code != want.mnemonic_code)
                report_mismatch("mnemonic_code", got.mnemonic_code, want.mnemonic_code);
            if (got.first_operand != want.first_operand)
                report_mismatch("first_operand", got.first_operand, want.first_operand);
            if (got.second_operand != want.second_operand)
                report_mismatch("second_operand", got.second_operand, want.second_operand);
            if (got.length_bytes != want.length_bytes)
                report_mismatch("length_bytes", got.length_bytes, want.length_bytes);
            if (got.base_cycles != want.base_cycles)
                report_mismatch("base_cycles", got.base_cycles, want.base_cycles);
            if (got.taken_cycles != want.taken_cycles)
                report_mismatch("taken_cycles", got.taken_cycles, want.taken_cycles);
            if (got.branch_kind != want.branch_kind)
                report_mismatch("branch_kind", got.branch_kind, want.branch_kind);
            if (got.prefixed != want.prefixed)
                report_mismatch("prefixed", got.prefixed, want.prefixed);
            if (got.opcode_value != want.opcode_value)
                report_mismatch("opcode_value", got.opcode_value, want.opcode_value);
            if (got.short_immediate != want.short_immediate)
                report_mismatch("short_immediate", got.short_immediate, want.short_immediate);
            if (got.long_immediate != want.long_immediate)
                report_mismatch("long_immediate", got.long_immediate, want.long_immediate);
        endtask
    endclass

    decode_scoreboard board = new();

    int send_idle = 17;
    int recv_idle = 54;
    bit hold_recv = 0;
    int quiet = 0;
    localparam int QUIET_LIMIT = 5000;

    initial clk = 0;
    always begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            board.note_input({first_byte, second_byte, third_byte, bytes_valid});
        if (rst_n && out_valid && !out_stall)
            board.check_result({mnemonic_code, first_operand, second_operand, length_bytes,
                base_cycles, taken_cycles, branch_kind, prefixed, opcode_value,
                short_immediate, long_immediate});
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("** eight_bit_cpu_instruction_decoder: FAILED **");
            $finish;
        end
        out_stall <= hold_recv || ($urandom_range(99) < recv_idle);
    end

    task automatic send_word(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [1:0] n);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_byte <= a;
        second_byte <= b;
        third_byte <= c;
        bytes_valid <= n;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        logic [7:0] op;
        for (int i = 0; i < count; i++) begin
            op = 8'($urandom_range(255));
            if ($urandom_range(9) == 0) op = PREFIX_OP;
            send_word(op, 8'($urandom), 8'($urandom),
                ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd3);
        end
    endtask

    initial begin
        rst_n = 0;
        in_valid = 0;
        first_byte = 0;
        second_byte = 0;
        third_byte = 0;
        bytes_valid = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_word(8'h00, 8'h00, 8'h00, 2'd0);
        send_word(8'hFF, 8'hFF, 8'hFF, 2'd0);
        send_word(PREFIX_OP, 8'h37, 8'h00, 2'd1);
        send_word(PREFIX_OP, 8'h00, 8'h00, 2'd2);
        send_word(PREFIX_OP, 8'hFF, 8'hFF, 2'd3);
        send_word(PREFIX_OP, 8'h46, 8'h00, 2'd2);
        send_word(PREFIX_OP, 8'h86, 8'h00, 2'd2);
        send_word(HALT_OP, 8'h00, 8'h00, 2'd1);
        send_word(8'h10, 8'hAA, 8'h55, 2'd3);
        send_word(8'hD3, 8'h00, 8'h00, 2'd1);
        send_word(8'hFD, 8'h00, 8'h00, 2'd1);
        send_word(8'hC3, 8'hFF, 8'hFF, 2'd3);
        send_word(8'hC3, 8'h12, 8'h34, 2'd2);
        send_word(8'hCD, 8'h34, 8'h12, 2'd1);
        send_word(8'h18, 8'hFF, 8'h00, 2'd2);
        send_word(8'h20, 8'h80, 8'h00, 2'd1);
        send_word(8'hE0, 8'h7F, 8'h00, 2'd2);
        send_word(8'h08, 8'h01, 8'h80, 2'd3);
        send_word(8'hFF, 8'h00, 8'h00, 2'd3);
        send_word(8'hC4, 8'hEE, 8'hDD, 2'd3);
        send_random(300);
        fork
            begin
                hold_recv = 1;
                repeat (60) @(posedge clk);
                hold_recv = 0;
            end
            send_random(20);
        join
        send_idle = 54;
        recv_idle = 17;
        send_random(300);
        send_idle = 0;
        recv_idle = 0;
        for (int op = 0; op < 256; op++) send_word(8'(op), 8'($urandom), 8'($urandom), 2'd3);
        send_random(60);
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("** eight_bit_cpu_instruction_decoder: PASSED **");
        else
            $display("** eight_bit_cpu_instruction_decoder: FAILED **");
        $finish;
    end
endmodule
